@@ rtl/core/asg_pkg.sv @@
// ----------------------------------------------------------------------------
// asg_pkg: shared definitions for the audio squelch gate
// link state codes, request codes, register map, reset values and the event
// bundle passed to the link controller
// ----------------------------------------------------------------------------
package asg_pkg;

   // link state codes
   localparam logic [1:0] StListen   = 2'd0;
   localparam logic [1:0] StReceive  = 2'd1;
   localparam logic [1:0] StTransmit = 2'd2;

   // request type codes
   localparam logic [1:0] ReqConversion = 2'd0;
   localparam logic [1:0] ReqTick       = 2'd1;
   localparam logic [1:0] ReqTxStart    = 2'd2;
   localparam logic [1:0] ReqTxStop     = 2'd3;

   // field widths
   localparam int AdcWidth      = 12;
   localparam int ChannelWidth  = 4;
   localparam int PercentWidth  = 7;
   localparam int OpenCntWidth  = 8;
   localparam int CloseCntWidth = 10;
   localparam int ChanLimWidth  = 5;
   localparam int ProductWidth  = 20;

   // register map
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam logic [2:0] RegCalibration = 3'd0;
   localparam logic [2:0] RegSquelchPct  = 3'd1;
   localparam logic [2:0] RegOpenDelay   = 3'd2;
   localparam logic [2:0] RegCloseDelay  = 3'd3;
   localparam logic [2:0] RegChannelLim  = 3'd4;

   // register reset values
   localparam logic [AdcWidth-1:0]      CalibrationReset = 12'd2048;
   localparam logic [PercentWidth-1:0]  SquelchPctReset  = 7'd0;
   localparam logic [OpenCntWidth-1:0]  OpenDelayReset   = 8'd1;
   localparam logic [CloseCntWidth-1:0] CloseDelayReset  = 10'd200;
   localparam logic [ChanLimWidth-1:0]  ChannelLimReset  = 5'd10;

   localparam int PercentScale = 100;

   localparam int SamplesPerGroupDefault = 4;

   // one accepted request as seen by the link controller
   typedef struct packed {
      logic accept;
      logic sample_hit;
      logic tick;
      logic tx_start;
      logic tx_stop;
   } link_event_type;

endpackage

@@ rtl/core/asg_band_check.sv @@
// ----------------------------------------------------------------------------
// asg_band_check: squelch band test
// flags a sample lying outside calibration * (100 +/- percent) / 100, worked
// out by cross-multiplying so that no divider is needed
// ----------------------------------------------------------------------------
module asg_band_check (
   input  logic [asg_pkg::AdcWidth-1:0]     sample,
   input  logic [asg_pkg::AdcWidth-1:0]     calibration,
   input  logic [asg_pkg::PercentWidth-1:0] percent,
   output logic                             above
);
   import asg_pkg::*;

   logic [7:0]              pct_hi;
   logic [PercentWidth-1:0] pct_lo;
   logic                    lo_used;
   logic [ProductWidth-1:0] hi_prod;
   logic [ProductWidth-1:0] lo_prod;
   logic [ProductWidth-1:0] scaled;

   always_comb begin
      pct_hi  = 8'(PercentScale) + 8'(percent);
      pct_lo  = 7'(PercentScale) - percent;
      lo_used = (percent <= 7'(PercentScale));
      hi_prod = ProductWidth'(calibration) * ProductWidth'(pct_hi);
      lo_prod = ProductWidth'(calibration) * ProductWidth'(pct_lo);
      scaled  = ProductWidth'(sample) * ProductWidth'(PercentScale);
      // s > floor(x/100) iff 100s > x ; s < floor(y/100) iff 100s + 100 <= y
      above = (scaled > hi_prod)
            || (lo_used && ((scaled + ProductWidth'(PercentScale)) <= lo_prod));
   end

endmodule

@@ rtl/core/asg_link_ctrl.sv @@
// ----------------------------------------------------------------------------
// asg_link_ctrl: link state and window counters
// holds the listening / receiving / transmitting state, the window hit mark
// and the open and close counters, stepped once per accepted request
// ----------------------------------------------------------------------------
module asg_link_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  asg_pkg::link_event_type           evt,
   input  logic [asg_pkg::OpenCntWidth-1:0]  open_delay,
   input  logic [asg_pkg::CloseCntWidth-1:0] close_delay,
   output logic [1:0]                        state_cur,
   output logic [1:0]                        state_next
);
   import asg_pkg::*;

   logic [1:0]               state_ff, state_in;
   logic                     hit_ff, hit_in;
   logic [OpenCntWidth-1:0]  open_ff, open_in;
   logic [CloseCntWidth-1:0] close_ff, close_in;
   logic                     open_reached;
   logic                     close_reached;

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      open_in  = open_ff;
      close_in = close_ff;
      open_reached  = 1'b0;
      close_reached = 1'b0;

      if (evt.sample_hit) begin
         hit_in = 1'b1;
      end

      if (evt.tick) begin
         if (hit_ff) begin
            close_in = '0;
            if (state_ff == StListen && open_ff != '1) begin
               open_in = open_ff + 1'b1;
            end
         end else begin
            open_in = '0;
            if (state_ff == StReceive && close_ff != '1) begin
               close_in = close_ff + 1'b1;
            end
         end
         hit_in = 1'b0;
         // a zero delay acts as a delay of one
         open_reached  = (open_delay == '0) ? (open_in != '0) : (open_in >= open_delay);
         if (state_in == StListen && open_reached) begin
            state_in = StReceive;
            open_in  = '0;
         end
         close_reached = (close_delay == '0) ? (close_in != '0)
                                             : (close_in >= close_delay);
         if (state_in == StReceive && close_reached) begin
            state_in = StListen;
            close_in = '0;
         end
      end

      if (evt.tx_start) begin
         state_in = StTransmit;
      end
      if (evt.tx_stop && state_ff == StTransmit) begin
         state_in = StListen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StListen;
         hit_ff   <= 1'b0;
         open_ff  <= '0;
         close_ff <= '0;
      end else if (evt.accept) begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         open_ff  <= open_in;
         close_ff <= close_in;
      end
   end

   assign state_cur  = state_ff;
   assign state_next = state_in;

`ifndef SYNTHESIS
   a_tick_clears_hit: assert property (@(posedge clock) disable iff (reset)
      evt.accept && evt.tick |=> !hit_ff)
      else $error("window hit survived a tick");

   a_listen_open_zero: assert property (@(posedge clock) disable iff (reset)
      evt.accept && evt.tick && state_ff == StListen && state_in == StReceive
      |=> open_ff == '0)
      else $error("open counter not cleared on opening");

   a_tx_start_state: assert property (@(posedge clock) disable iff (reset)
      evt.accept && evt.tx_start |=> state_ff == StTransmit)
      else $error("transmit start did not reach transmitting");
`endif

endmodule

@@ rtl/core/audio_squelch_gate_unit.sv @@
// ----------------------------------------------------------------------------
// audio_squelch_gate_unit: squelch and link-state control for an ADC stream
// averages groups of conversions, tests them against the squelch band and
// moves the link between listening, receiving and transmitting
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   req_type, req_adc_code, req_adc_channel
//  rsp_      out        rsp_valid / rsp_ready   audio_state, sample_valid,
//                                               averaged_sample, above_squelch
//  csr_      in         apb, pready tied high   calibration, percent, delays, limit
//
//  one request per clock unless rsp_ready holds the output; its single result sits in the
//  output register in the cycle after acceptance, and throughput is one per cycle
//  the rate is set by the state update loop: link / group state register,
//  one pass of next-state logic, back into the same register
//  a new request is taken while a result waits as long as rsp_ready is high
//  synchronous reset restores every control register and csr at once, no sweep
//  req_ready is held low during reset
//
module audio_squelch_gate_unit #(
   parameter int SAMPLES_PER_GROUP = asg_pkg::SamplesPerGroupDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [asg_pkg::AdcWidth-1:0]      req_adc_code,
   input  logic [asg_pkg::ChannelWidth-1:0]  req_adc_channel,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_audio_state,
   output logic                              rsp_sample_valid,
   output logic [asg_pkg::AdcWidth-1:0]      rsp_averaged_sample,
   output logic                              rsp_above_squelch,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [asg_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [asg_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [asg_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import asg_pkg::*;

   localparam int PosWidth = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(SAMPLES_PER_GROUP - 1);

   // configuration registers
   logic [AdcWidth-1:0]      cal_ff;
   logic [PercentWidth-1:0]  pct_ff;
   logic [OpenCntWidth-1:0]  open_dly_ff;
   logic [CloseCntWidth-1:0] close_dly_ff;
   logic [ChanLimWidth-1:0]  chan_lim_ff;
   logic                     csr_write;
   logic [2:0]               csr_index;

   // group averaging state
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [AdcWidth-1:0] avg_ff, avg_in;

   // result register
   logic                rsp_valid_ff;
   logic [1:0]          rsp_state_ff;
   logic                rsp_sval_ff;
   logic [AdcWidth-1:0] rsp_avg_ff;
   logic                rsp_above_ff;

   logic                accept;
   logic                is_conv;
   logic                group_last;
   logic [AdcWidth:0]   pair_sum;
   logic [AdcWidth-1:0] new_avg;
   logic                sample_ok;
   logic                band_above;
   logic                sample_hit;
   logic [1:0]          link_cur;
   logic [1:0]          link_next;
   link_event_type      evt;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff       <= CalibrationReset;
         pct_ff       <= SquelchPctReset;
         open_dly_ff  <= OpenDelayReset;
         close_dly_ff <= CloseDelayReset;
         chan_lim_ff  <= ChannelLimReset;
      end else if (csr_write) begin
         case (csr_index)
            RegCalibration: cal_ff       <= csr_pwdata[AdcWidth-1:0];
            RegSquelchPct:  pct_ff       <= csr_pwdata[PercentWidth-1:0];
            RegOpenDelay:   open_dly_ff  <= csr_pwdata[OpenCntWidth-1:0];
            RegCloseDelay:  close_dly_ff <= csr_pwdata[CloseCntWidth-1:0];
            RegChannelLim:  chan_lim_ff  <= csr_pwdata[ChanLimWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegCalibration: csr_prdata = CsrDataWidth'(cal_ff);
         RegSquelchPct:  csr_prdata = CsrDataWidth'(pct_ff);
         RegOpenDelay:   csr_prdata = CsrDataWidth'(open_dly_ff);
         RegCloseDelay:  csr_prdata = CsrDataWidth'(close_dly_ff);
         RegChannelLim:  csr_prdata = CsrDataWidth'(chan_lim_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // the output register frees up when its result is taken in the same cycle
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- averaging
   always_comb begin
      // conversions are dropped while transmitting
      is_conv    = (req_type == ReqConversion) && (link_cur != StTransmit);
      group_last = (pos_ff == LastPos);
      pair_sum   = {1'b0, avg_ff} + {1'b0, req_adc_code};
      // first of a group is kept, later ones are folded in by halving
      new_avg    = (pos_ff == '0) ? req_adc_code : pair_sum[AdcWidth:1];
      sample_ok  = is_conv && group_last
                && ({1'b0, req_adc_channel} < chan_lim_ff);
      sample_hit = sample_ok && band_above;

      pos_in = pos_ff;
      avg_in = avg_ff;
      if (is_conv) begin
         avg_in = new_avg;
         pos_in = group_last ? '0 : PosWidth'(pos_ff + 1'b1);
      end
      // transmit start, and a stop that ends transmitting, drop the partial group
      if (req_type == ReqTxStart
          || (req_type == ReqTxStop && link_cur == StTransmit)) begin
         pos_in = '0;
      end
   end

   asg_band_check u_band_check (
      .sample      (new_avg),
      .calibration (cal_ff),
      .percent     (pct_ff),
      .above       (band_above)
   );

   // ---------------------------------------------------------------- link state
   always_comb begin
      evt.accept     = accept;
      evt.sample_hit = sample_hit;
      evt.tick       = (req_type == ReqTick);
      evt.tx_start   = (req_type == ReqTxStart);
      evt.tx_stop    = (req_type == ReqTxStop);
   end

   asg_link_ctrl u_link_ctrl (
      .clock       (clock),
      .reset       (reset),
      .evt         (evt),
      .open_delay  (open_dly_ff),
      .close_delay (close_dly_ff),
      .state_cur   (link_cur),
      .state_next  (link_next)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         avg_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_state_ff <= link_next;
         rsp_sval_ff  <= sample_ok;
         rsp_avg_ff   <= sample_ok ? new_avg : '0;
         rsp_above_ff <= sample_hit;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_audio_state     = rsp_state_ff;
   assign rsp_sample_valid    = rsp_sval_ff;
   assign rsp_averaged_sample = rsp_avg_ff;
   assign rsp_above_squelch   = rsp_above_ff;

`ifndef SYNTHESIS
   a_no_sample_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_valid
      |-> rsp_averaged_sample == '0 && !rsp_above_squelch)
      else $error("payload set without a valid sample");

   a_above_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_above_squelch |-> rsp_sample_valid)
      else $error("squelch flag without a valid sample");

   a_tx_drops_samples: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == ReqConversion && link_cur == StTransmit
      |=> !rsp_sample_valid && rsp_audio_state == StTransmit)
      else $error("conversion acted on while transmitting");

   a_tx_start_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == ReqTxStart
      |=> rsp_valid && rsp_audio_state == StTransmit && pos_ff == '0)
      else $error("transmit start not reflected in result");
`endif

endmodule
